/* hw/rtl/bpg_pkg.sv */
package bpg_pkg;

	localparam int unsigned FRACTION_BITS = 8;
	localparam int unsigned CNT_W = 64;
	localparam int unsigned NUM_W = CNT_W + 7 + FRACTION_BITS;
	localparam int unsigned ITER_W = $clog2(NUM_W + 1);
	localparam int unsigned RATIO_W = 8 + FRACTION_BITS;
	localparam int unsigned ERR_W = 33;
	localparam int unsigned PERR_W = 32;
	localparam int unsigned INTEG_W = 14;
	localparam int unsigned ACC_W = 40;
	localparam int unsigned MA_W = 42;
	localparam int unsigned MB_W = 18;
	localparam int unsigned MP_W = MA_W + MB_W;
	localparam int unsigned TGT_W = 42;
	localparam int unsigned INTEG_LIMIT = 30 << FRACTION_BITS;
	localparam int unsigned FLOOR_RUN = 5;
	localparam int unsigned FREQ_MUL = 1000;
	localparam int unsigned PCT = 100;
	localparam int unsigned ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_SETPOINT = 3'd0,
		REG_DEADBAND = 3'd1,
		REG_P_GAIN   = 3'd2,
		REG_I_GAIN   = 3'd3,
		REG_D_GAIN   = 3'd4,
		REG_MIN      = 3'd5,
		REG_MAX      = 3'd6,
		REG_BOUNDS   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [6:0]  setpoint;
		logic [6:0]  deadband;
		logic [8:0]  p_gain;
		logic [8:0]  i_gain;
		logic [8:0]  d_gain;
		logic [7:0]  min_ratio;
		logic [7:0]  max_ratio;
		logic [15:0] pstate_bounds;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	function automatic logic [7:0] clamp_state(logic signed [TGT_W-1:0] t,
			logic [15:0] b);
		logic signed [TGT_W-1:0] lo;
		logic signed [TGT_W-1:0] hi;
		logic signed [TGT_W-1:0] v;
		lo = signed'({{(TGT_W-8){1'b0}}, b[7:0]});
		hi = signed'({{(TGT_W-8){1'b0}}, b[15:8]});
		v = t;
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return v[7:0];
	endfunction

endpackage

/* hw/rtl/bpg_in_if.sv */
interface bpg_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] actual_count;
	logic [63:0] reference_count;

	modport source (output valid, output actual_count, output reference_count, input ready);
	modport sink (input valid, input actual_count, input reference_count, output ready);
endinterface

/* hw/rtl/bpg_out_if.sv */
interface bpg_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  new_pstate;
	logic        pstate_changed;
	logic [31:0] freq_khz;
	logic        sample_error;

	modport source (output valid, output new_pstate, output pstate_changed,
		output freq_khz, output sample_error, input ready);
	modport sink (input valid, input new_pstate, input pstate_changed,
		input freq_khz, input sample_error, output ready);
endinterface

/* hw/rtl/bpg_cfg.sv */
module bpg_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [bpg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output bpg_pkg::cfg_t             cfg
);
	bpg_pkg::cfg_t cfg_q;
	bpg_pkg::reg_idx_t idx;

	assign idx = bpg_pkg::reg_idx_t'(paddr[bpg_pkg::ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint <= 7'd97;
			cfg_q.deadband <= 7'd0;
			cfg_q.p_gain <= 9'd51;
			cfg_q.i_gain <= 9'd0;
			cfg_q.d_gain <= 9'd0;
			cfg_q.min_ratio <= 8'd16;
			cfg_q.max_ratio <= 8'd34;
			cfg_q.pstate_bounds <= 16'd8720;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				bpg_pkg::REG_SETPOINT: cfg_q.setpoint <= pwdata[6:0];
				bpg_pkg::REG_DEADBAND: cfg_q.deadband <= pwdata[6:0];
				bpg_pkg::REG_P_GAIN:   cfg_q.p_gain <= pwdata[8:0];
				bpg_pkg::REG_I_GAIN:   cfg_q.i_gain <= pwdata[8:0];
				bpg_pkg::REG_D_GAIN:   cfg_q.d_gain <= pwdata[8:0];
				bpg_pkg::REG_MIN:      cfg_q.min_ratio <= pwdata[7:0];
				bpg_pkg::REG_MAX:      cfg_q.max_ratio <= pwdata[7:0];
				bpg_pkg::REG_BOUNDS:   cfg_q.pstate_bounds <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			bpg_pkg::REG_SETPOINT: prdata = {25'd0, cfg_q.setpoint};
			bpg_pkg::REG_DEADBAND: prdata = {25'd0, cfg_q.deadband};
			bpg_pkg::REG_P_GAIN:   prdata = {23'd0, cfg_q.p_gain};
			bpg_pkg::REG_I_GAIN:   prdata = {23'd0, cfg_q.i_gain};
			bpg_pkg::REG_D_GAIN:   prdata = {23'd0, cfg_q.d_gain};
			bpg_pkg::REG_MIN:      prdata = {24'd0, cfg_q.min_ratio};
			bpg_pkg::REG_MAX:      prdata = {24'd0, cfg_q.max_ratio};
			bpg_pkg::REG_BOUNDS:   prdata = {16'd0, cfg_q.pstate_bounds};
		endcase
	end
endmodule

/* hw/rtl/bpg_div.sv */
module bpg_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bpg_pkg::div_req_t          req,
	input  logic [bpg_pkg::NUM_W-1:0]  dividend,
	input  logic [bpg_pkg::CNT_W-1:0]  divisor,
	output logic                       busy,
	output logic [31:0]                quotient
);
	logic [bpg_pkg::ITER_W-1:0] cnt_q;
	logic [bpg_pkg::NUM_W-1:0]  num_q;
	logic [bpg_pkg::CNT_W-1:0]  den_q;
	logic [bpg_pkg::CNT_W-1:0]  rem_q;
	logic [31:0]                quo_q;
	logic                       over_q;
	logic [bpg_pkg::CNT_W:0]    remx;
	logic                       ge;

	// dividend is left-aligned: one bit enters the remainder per step
	assign remx = {rem_q, num_q[bpg_pkg::NUM_W-1]};
	assign ge = remx >= {1'b0, den_q};
	assign busy = cnt_q != '0;
	assign quotient = over_q ? 32'hFFFF_FFFF : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= req.iters;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			over_q <= 1'b0;
		end else if (busy) begin
			num_q <= {num_q[bpg_pkg::NUM_W-2:0], 1'b0};
			rem_q <= ge ? remx[bpg_pkg::CNT_W-1:0] - den_q : remx[bpg_pkg::CNT_W-1:0];
			quo_q <= {quo_q[30:0], ge};
			over_q <= over_q | quo_q[31];
		end
	end
endmodule

/* hw/rtl/busy_pid_pstate_governor.sv */
// Busy-driven performance-state governor with PID control.
// The shared bit-serial divider dominates the time from input accept to result valid;
// priming or a zero reference delta skips it, and inside the deadband the PID steps are skipped.
// Input is not ready while an item is worked; the next item waits for the last result.
// Reset: arst_n clears controller state; the first item primes counters and moves to max.
// Configuration registers return to their documented defaults on reset.
module busy_pid_pstate_governor (
	input  logic                        clk,
	input  logic                        arst_n,
	bpg_in_if.sink                      in_ch,
	bpg_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpg_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	localparam int unsigned F = bpg_pkg::FRACTION_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_DIVB, S_RSTART, S_DIVR, S_FREQ1, S_FREQ2, S_SCALE,
		S_ERR, S_P, S_D, S_I, S_APPLY, S_FLOOR, S_OUT
	} state_t;

	bpg_pkg::cfg_t cfg;
	state_t state_q;

	logic [63:0] prev_a_q, prev_r_q, da_q, dr_q;
	logic [7:0]  cur_q;
	logic signed [bpg_pkg::INTEG_W-1:0] integ_q;
	logic signed [bpg_pkg::PERR_W-1:0]  perr_q;
	logic [2:0]  frun_q;
	logic        primed_q;
	logic [31:0] core_q;
	logic [bpg_pkg::RATIO_W-1:0] ratio_q;
	logic [39:0] t_q;
	logic [31:0] freq_q;
	logic [30:0] scaled_q;
	logic signed [bpg_pkg::ERR_W-1:0] err_q;
	logic signed [bpg_pkg::ACC_W-1:0] acc_q;
	logic        chg_q, serr_q;
	logic        ov_q;
	logic [7:0]  o_state_q;
	logic        o_chg_q, o_serr_q;
	logic [31:0] o_freq_q;

	bpg_pkg::div_req_t div_req;
	logic [bpg_pkg::NUM_W-1:0] div_num;
	logic [63:0] div_den;
	logic        div_busy;
	logic [31:0] div_quo;

	logic signed [bpg_pkg::MA_W-1:0] mul_a;
	logic signed [bpg_pkg::MB_W-1:0] mul_b;
	logic signed [bpg_pkg::MP_W-1:0] prod, prod_sh;

	logic signed [bpg_pkg::ERR_W-1:0] err_c;
	logic [bpg_pkg::ERR_W-1:0] mag_c;
	logic signed [bpg_pkg::ERR_W:0] diff_c;
	logic signed [bpg_pkg::ERR_W:0] isum_c;
	logic signed [bpg_pkg::ACC_W-1:0] ctl_c;
	logic signed [bpg_pkg::TGT_W-1:0] tgt_c;
	logic [7:0]  new_c, max_c;
	logic [2:0]  frun_n;
	logic [70:0] da100;

	bpg_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	bpg_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .dividend(div_num),
		.divisor(div_den), .busy(div_busy), .quotient(div_quo)
	);

	assign in_ch.ready = state_q == S_IDLE;
	assign out_ch.valid = ov_q;
	assign out_ch.new_pstate = o_state_q;
	assign out_ch.pstate_changed = o_chg_q;
	assign out_ch.freq_khz = o_freq_q;
	assign out_ch.sample_error = o_serr_q;

	// da*100 as shifts and adds
	assign da100 = {1'b0, da_q, 6'd0} + {2'b0, da_q, 5'd0} + {5'b0, da_q, 2'd0};

	always_comb begin
		div_req.start = 1'b0;
		div_req.iters = bpg_pkg::ITER_W'(bpg_pkg::NUM_W);
		div_num = {da100, {F{1'b0}}};
		div_den = dr_q;
		if (state_q == S_CHECK && primed_q && dr_q != '0) begin
			div_req.start = 1'b1;
		end else if (state_q == S_RSTART) begin
			div_req.start = 1'b1;
			div_req.iters = bpg_pkg::ITER_W'(bpg_pkg::RATIO_W);
			div_num = {cfg.max_ratio, {F{1'b0}}, {(bpg_pkg::NUM_W-bpg_pkg::RATIO_W){1'b0}}};
			div_den = {56'd0, (cur_q == 8'd0) ? 8'd1 : cur_q};
		end
	end

	assign diff_c = {err_q[bpg_pkg::ERR_W-1], err_q}
		- {{(bpg_pkg::ERR_W+1-bpg_pkg::PERR_W){perr_q[bpg_pkg::PERR_W-1]}}, perr_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_FREQ1: begin
				mul_a = signed'({10'd0, core_q});
				mul_b = signed'({10'd0, cfg.max_ratio});
			end
			S_FREQ2: begin
				mul_a = signed'({2'd0, t_q});
				mul_b = bpg_pkg::MB_W'(bpg_pkg::FREQ_MUL);
			end
			S_SCALE: begin
				mul_a = signed'({10'd0, core_q});
				mul_b = signed'({{(bpg_pkg::MB_W-bpg_pkg::RATIO_W){1'b0}}, ratio_q});
			end
			S_P: begin
				mul_a = {{(bpg_pkg::MA_W-bpg_pkg::ERR_W){err_q[bpg_pkg::ERR_W-1]}}, err_q};
				mul_b = signed'({9'd0, cfg.p_gain});
			end
			S_D: begin
				mul_a = {{(bpg_pkg::MA_W-bpg_pkg::ERR_W-1){diff_c[bpg_pkg::ERR_W]}}, diff_c};
				mul_b = signed'({9'd0, cfg.d_gain});
			end
			S_I: begin
				mul_a = {{(bpg_pkg::MA_W-bpg_pkg::INTEG_W){integ_q[bpg_pkg::INTEG_W-1]}},
					integ_q};
				mul_b = signed'({9'd0, cfg.i_gain});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign prod_sh = prod >>> F;

	assign err_c = signed'({{(bpg_pkg::ERR_W-7-F){1'b0}}, cfg.setpoint, {F{1'b0}}})
		- signed'({2'b0, scaled_q});
	assign mag_c = err_c[bpg_pkg::ERR_W-1] ? unsigned'(-err_c) : unsigned'(err_c);
	assign isum_c = {{(bpg_pkg::ERR_W+1-bpg_pkg::INTEG_W){integ_q[bpg_pkg::INTEG_W-1]}},
		integ_q} + {err_q[bpg_pkg::ERR_W-1], err_q};
	assign ctl_c = acc_q >>> F;
	assign tgt_c = signed'({{(bpg_pkg::TGT_W-8){1'b0}}, cur_q})
		- {{(bpg_pkg::TGT_W-bpg_pkg::ACC_W){ctl_c[bpg_pkg::ACC_W-1]}}, ctl_c};
	assign new_c = bpg_pkg::clamp_state(tgt_c, cfg.pstate_bounds);
	assign max_c = bpg_pkg::clamp_state(
		signed'({{(bpg_pkg::TGT_W-8){1'b0}}, cfg.max_ratio}), cfg.pstate_bounds);
	assign frun_n = frun_q + 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prev_a_q <= '0;
			prev_r_q <= '0;
			cur_q <= '0;
			integ_q <= '0;
			perr_q <= '0;
			frun_q <= '0;
			primed_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one is loaded below
			if (ov_q && out_ch.ready && state_q != S_OUT) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						da_q <= in_ch.actual_count - prev_a_q;
						dr_q <= in_ch.reference_count - prev_r_q;
						prev_a_q <= in_ch.actual_count;
						prev_r_q <= in_ch.reference_count;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					freq_q <= '0;
					if (!primed_q) begin
						primed_q <= 1'b1;
						chg_q <= max_c != cur_q;
						serr_q <= 1'b0;
						cur_q <= max_c;
						integ_q <= '0;
						perr_q <= signed'({25'd0, cfg.setpoint})
							- bpg_pkg::PERR_W'(bpg_pkg::PCT);
						frun_q <= '0;
						state_q <= S_OUT;
					end else if (dr_q == '0) begin
						chg_q <= 1'b0;
						serr_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						chg_q <= 1'b0;
						serr_q <= 1'b0;
						state_q <= S_DIVB;
					end
				end
				S_DIVB: begin
					if (!div_busy) begin
						core_q <= div_quo;
						state_q <= S_RSTART;
					end
				end
				S_RSTART: state_q <= S_DIVR;
				S_DIVR: begin
					if (!div_busy) begin
						ratio_q <= div_quo[bpg_pkg::RATIO_W-1:0];
						state_q <= S_FREQ1;
					end
				end
				S_FREQ1: begin
					t_q <= prod[39:0];
					state_q <= S_FREQ2;
				end
				S_FREQ2: begin
					freq_q <= (|prod_sh[bpg_pkg::MP_W-1:32]) ? 32'hFFFF_FFFF : prod_sh[31:0];
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					scaled_q <= (|prod_sh[bpg_pkg::MP_W-1:31]) ? 31'h7FFF_FFFF : prod_sh[30:0];
					state_q <= S_ERR;
				end
				S_ERR: begin
					err_q <= err_c;
					acc_q <= '0;
					// inside the deadband: no control action, PID state held
					if (mag_c <= {{(bpg_pkg::ERR_W-7-F){1'b0}}, cfg.deadband, {F{1'b0}}})
						state_q <= S_APPLY;
					else
						state_q <= S_P;
				end
				S_P: begin
					acc_q <= acc_q + prod_sh[bpg_pkg::ACC_W-1:0];
					if (isum_c > signed'((bpg_pkg::ERR_W+1)'(bpg_pkg::INTEG_LIMIT)))
						integ_q <= bpg_pkg::INTEG_W'(bpg_pkg::INTEG_LIMIT);
					else if (isum_c < -signed'((bpg_pkg::ERR_W+1)'(bpg_pkg::INTEG_LIMIT)))
						integ_q <= -bpg_pkg::INTEG_W'(bpg_pkg::INTEG_LIMIT);
					else
						integ_q <= isum_c[bpg_pkg::INTEG_W-1:0];
					state_q <= S_D;
				end
				S_D: begin
					acc_q <= acc_q + prod_sh[bpg_pkg::ACC_W-1:0];
					perr_q <= err_q[bpg_pkg::PERR_W-1:0];
					state_q <= S_I;
				end
				S_I: begin
					acc_q <= acc_q + prod_sh[bpg_pkg::ACC_W-1:0];
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (new_c != cur_q) chg_q <= 1'b1;
					cur_q <= new_c;
					state_q <= S_FLOOR;
				end
				S_FLOOR: begin
					if (cur_q == cfg.min_ratio) begin
						if (frun_n >= 3'(bpg_pkg::FLOOR_RUN)) begin
							frun_q <= '0;
							if (max_c != cur_q) chg_q <= 1'b1;
							cur_q <= max_c;
						end else begin
							frun_q <= frun_n;
						end
					end else begin
						frun_q <= '0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!ov_q || out_ch.ready) begin
						ov_q <= 1'b1;
						o_state_q <= cur_q;
						o_chg_q <= chg_q;
						o_freq_q <= freq_q;
						o_serr_q <= serr_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* tb/busy_pid_pstate_governor_test.sv */
`timescale 1ns / 100ps

module busy_pid_pstate_governor_test;

	localparam int unsigned WATCHDOG_LIMIT = 6000;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS = 250;
	localparam int unsigned NUM_PHASES = 8;

	typedef struct packed {
		logic [7:0]  pstate;
		logic        changed;
		logic [31:0] freq;
		logic        skipped;
	} sample_result_t;

	typedef struct {
		logic [63:0]    d_act;
		logic [63:0]    d_ref;
		bit             typed;
		sample_result_t res;
	} sample_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [bpg_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	bpg_in_if in_ch ();
	bpg_out_if out_ch ();

	busy_pid_pstate_governor u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the configuration registers
	logic [6:0]  sh_setpoint;
	logic [6:0]  sh_deadband;
	logic [8:0]  sh_p_gain, sh_i_gain, sh_d_gain;
	logic [7:0]  sh_min, sh_max;
	logic [15:0] sh_bounds;

	// governor state as predicted
	logic [63:0] gv_prev_act, gv_prev_ref;
	logic [7:0]  gv_pstate;
	longint      gv_integral;
	longint      gv_last_err;
	int          gv_floor_run;
	bit          gv_primed;

	sample_result_t pending_results[$];
	int unsigned errors;
	int unsigned items_sent, results_seen, skipped_seen, changes_seen;
	logic [63:0] cnt_act, cnt_ref;
	bit no_idle;
	bit long_hold_req;
	int unsigned busy_pct_hi;
	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit move_state(longint target);
		longint lo, hi;
		lo = longint'(sh_bounds[7:0]);
		hi = longint'(sh_bounds[15:8]);
		if (target < lo) target = lo;
		if (target > hi) target = hi;
		if (target[7:0] == gv_pstate) return 1'b0;
		gv_pstate = target[7:0];
		return 1'b1;
	endfunction

	function automatic longint pid_control(longint busy);
		longint err, mag, lim, pterm, iterm, dterm;
		err = (longint'(sh_setpoint) <<< bpg_pkg::FRACTION_BITS) - busy;
		mag = err < 0 ? -err : err;
		lim = longint'(bpg_pkg::INTEG_LIMIT);
		if (mag <= (longint'(sh_deadband) <<< bpg_pkg::FRACTION_BITS)) return 0;
		pterm = (longint'(sh_p_gain) * err) >>> bpg_pkg::FRACTION_BITS;
		gv_integral = gv_integral + err;
		if (gv_integral > lim) gv_integral = lim;
		if (gv_integral < -lim) gv_integral = -lim;
		dterm = (longint'(sh_d_gain) * (err - gv_last_err)) >>> bpg_pkg::FRACTION_BITS;
		gv_last_err = err;
		iterm = (gv_integral * longint'(sh_i_gain)) >>> bpg_pkg::FRACTION_BITS;
		return (pterm + iterm + dterm) >>> bpg_pkg::FRACTION_BITS;
	endfunction

	function automatic sample_result_t governor_step(logic [63:0] act, logic [63:0] refc);
		sample_result_t r;
		logic [63:0]  da, dr, core, freq, ratio, scaled, cdiv;
		logic [127:0] num, quo;
		longint ctl;
		da = act - gv_prev_act;
		dr = refc - gv_prev_ref;
		gv_prev_act = act;
		gv_prev_ref = refc;
		r.changed = 1'b0;
		r.freq = '0;
		r.skipped = 1'b0;
		if (!gv_primed) begin
			gv_primed = 1'b1;
			r.changed = move_state(longint'(sh_max));
			gv_integral = 0;
			gv_last_err = longint'(sh_setpoint) - 100;
			gv_floor_run = 0;
			r.pstate = gv_pstate;
			return r;
		end
		if (dr == 0) begin
			r.pstate = gv_pstate;
			r.skipped = 1'b1;
			return r;
		end
		num = ({64'd0, da} * 128'd100) << bpg_pkg::FRACTION_BITS;
		quo = num / {64'd0, dr};
		core = (quo > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : quo[63:0];
		freq = (64'(sh_max) * core * 64'd1000) >> bpg_pkg::FRACTION_BITS;
		r.freq = (freq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : freq[31:0];
		cdiv = (gv_pstate == 0) ? 64'd1 : 64'(gv_pstate);
		ratio = (64'(sh_max) << bpg_pkg::FRACTION_BITS) / cdiv;
		scaled = (core * ratio) >> bpg_pkg::FRACTION_BITS;
		if (scaled > 64'h7FFF_FFFF) scaled = 64'h7FFF_FFFF;
		ctl = pid_control(longint'(scaled));
		if (move_state(longint'(gv_pstate) - ctl)) r.changed = 1'b1;
		if (gv_pstate == sh_min) begin
			gv_floor_run++;
			if (gv_floor_run >= bpg_pkg::FLOOR_RUN) begin
				gv_floor_run = 0;
				if (move_state(longint'(sh_max))) r.changed = 1'b1;
			end
		end else begin
			gv_floor_run = 0;
		end
		r.pstate = gv_pstate;
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle) return 0;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(12, 4);
		return $urandom_range(80, 20);
	endfunction

	task automatic send_sample(logic [63:0] da, logic [63:0] dr, bit typed,
			sample_result_t typed_res);
		sample_result_t r;
		int unsigned gap;
		cnt_act = cnt_act + da;
		cnt_ref = cnt_ref + dr;
		r = governor_step(cnt_act, cnt_ref);
		if (typed) begin
			if (r != typed_res)
				report("listed result", 64'(r), 64'(typed_res));
			r = typed_res;
		end
		pending_results.push_back(r);
		in_ch.valid <= 1'b1;
		in_ch.actual_count <= cnt_act;
		in_ch.reference_count <= cnt_ref;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random();
		logic [63:0] da, dr;
		sample_result_t none;
		int unsigned mode, pct;
		none = '{default: '0};
		mode = $urandom_range(99);
		if (mode < 72) begin
			dr = 64'($urandom_range(200000, 500));
			pct = $urandom_range(busy_pct_hi);
			da = dr * pct / 100;
		end else if (mode < 80) begin
			dr = '0;
			da = {$urandom, $urandom};
		end else if (mode < 90) begin
			dr = {$urandom, $urandom};
			da = {$urandom, $urandom};
		end else begin
			dr = 64'($urandom_range(3, 1));
			da = {32'd0, $urandom};
		end
		send_sample(da, dr, 1'b0, none);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic reg_write(bpg_pkg::reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= bpg_pkg::ADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		unique case (idx)
			bpg_pkg::REG_SETPOINT: sh_setpoint = value[6:0];
			bpg_pkg::REG_DEADBAND: sh_deadband = value[6:0];
			bpg_pkg::REG_P_GAIN:   sh_p_gain = value[8:0];
			bpg_pkg::REG_I_GAIN:   sh_i_gain = value[8:0];
			bpg_pkg::REG_D_GAIN:   sh_d_gain = value[8:0];
			bpg_pkg::REG_MIN:      sh_min = value[7:0];
			bpg_pkg::REG_MAX:      sh_max = value[7:0];
			bpg_pkg::REG_BOUNDS:   sh_bounds = value[15:0];
		endcase
	endtask

	task automatic configure(int sp, int db, int pg, int ig, int dg, int mn, int mx,
			int bd);
		reg_write(bpg_pkg::REG_SETPOINT, sp);
		reg_write(bpg_pkg::REG_DEADBAND, db);
		reg_write(bpg_pkg::REG_P_GAIN, pg);
		reg_write(bpg_pkg::REG_I_GAIN, ig);
		reg_write(bpg_pkg::REG_D_GAIN, dg);
		reg_write(bpg_pkg::REG_MIN, mn);
		reg_write(bpg_pkg::REG_MAX, mx);
		reg_write(bpg_pkg::REG_BOUNDS, bd);
	endtask

	// result side: check, then choose ready for the next cycle
	initial begin
		int unsigned stall;
		sample_result_t want;
		stall = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					report("unexpected result", 64'd1, 64'd0);
				end else begin
					want = pending_results.pop_front();
					if (out_ch.new_pstate !== want.pstate)
						report("new_pstate", out_ch.new_pstate, want.pstate);
					if (out_ch.pstate_changed !== want.changed)
						report("pstate_changed", out_ch.pstate_changed, want.changed);
					if (out_ch.freq_khz !== want.freq)
						report("freq_khz", out_ch.freq_khz, want.freq);
					if (out_ch.sample_error !== want.skipped)
						report("sample_error", out_ch.sample_error, want.skipped);
					if (want.skipped) skipped_seen++;
					if (want.changed) changes_seen++;
				end
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall = 600;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				stall--;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(3) == 0) stall = pick_gap();
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d quiet cycles", idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		sample_row_t rows[$];
		sample_row_t row;
		sample_result_t none;

		none = '{default: '0};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.actual_count <= '0;
		in_ch.reference_count <= '0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		skipped_seen = 0;
		changes_seen = 0;
		cnt_act = '0;
		cnt_ref = '0;
		no_idle = 1'b0;
		long_hold_req = 1'b0;
		busy_pct_hi = 150;
		sh_setpoint = 7'd97;
		sh_deadband = 7'd0;
		sh_p_gain = 9'd51;
		sh_i_gain = 9'd0;
		sh_d_gain = 9'd0;
		sh_min = 8'd16;
		sh_max = 8'd34;
		sh_bounds = 16'd8720;
		gv_prev_act = '0;
		gv_prev_ref = '0;
		gv_pstate = '0;
		gv_integral = 0;
		gv_last_err = 0;
		gv_floor_run = 0;
		gv_primed = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// priming sample, then a zero reference step, then extremes
		rows.push_back('{64'd1000, 64'd1000, 1'b1, '{8'd34, 1'b1, 32'd0, 1'b0}});
		rows.push_back('{64'd1000, 64'd0, 1'b1, '{8'd34, 1'b0, 32'd0, 1'b1}});
		rows.push_back('{64'd0, 64'd1000, 1'b0, none});
		rows.push_back('{64'd1000, 64'd1000, 1'b0, none});
		rows.push_back('{'1, 64'd1, 1'b0, none});
		rows.push_back('{64'd0, '1, 1'b0, none});
		rows.push_back('{'1, '1, 1'b0, none});
		rows.push_back('{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, none});
		rows.push_back('{64'd3000, 64'd1000, 1'b0, none});
		// idle load walks the state to the floor and trips the floor-run reset
		repeat (7) rows.push_back('{64'd0, 64'd5000, 1'b0, none});
		rows.push_back('{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, none});
		rows.push_back('{64'd0, 64'd0, 1'b0, none});
		foreach (rows[i]) begin
			row = rows[i];
			send_sample(row.d_act, row.d_ref, row.typed, row.res);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			busy_pct_hi = 150;
			no_idle = 1'b0;
			unique case (ph)
				0: ;
				1: configure(0, 100, 256, 256, 256, 0, 255, 65535);
				2: configure(100, 0, 256, 256, 256, 1, 1, 0);
				3: begin
					configure(100, 0, 256, 0, 0, 20, 200, (200 << 8) | 20);
					busy_pct_hi = 30;
				end
				4: configure(50, 3, 128, 64, 32, 200, 120, (10 << 8) | 200);
				default: configure($urandom_range(100), $urandom_range(100),
					$urandom_range(256), $urandom_range(256), $urandom_range(256),
					$urandom_range(255), $urandom_range(255, 1), $urandom_range(65535));
			endcase
			if (ph == 5) no_idle = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == 40) long_hold_req = 1'b1;
				if (ph == 2 && n == 100) begin
					// hold off until the block has emptied
					in_ch.valid <= 1'b0;
					while (pending_results.size() != 0) @(posedge clk);
				end
				send_random();
			end
		end

		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples over %0d register settings; %0d results checked",
			items_sent, NUM_PHASES, results_seen);
		$display("%0d zero-reference skips, %0d state changes, %0d mismatches",
			skipped_seen, changes_seen, errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
